### sv/llt_pkg.sv
// Shared types and constants for the logic language tokenizer.
// Used by the lexer, the token queue, the result serializer and the top level.
package llt_pkg;

  // Token length limit: a token is cut when it reaches TokenLimit - 1 characters.
  localparam int TokenLimit = 32;
  localparam int LenW       = $clog2(TokenLimit);
  localparam int LenOutW    = 5;
  // Entries in the queue between lexer and serializer.
  localparam int FifoDepth  = 4;

  // Character codes the lexer reacts to.
  localparam logic [7:0] ChNul        = 8'h00;
  localparam logic [7:0] ChTab        = 8'h09;
  localparam logic [7:0] ChLf         = 8'h0A;
  localparam logic [7:0] ChCr         = 8'h0D;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChHash       = 8'h23;
  localparam logic [7:0] ChMinus      = 8'h2D;
  localparam logic [7:0] ChSlash      = 8'h2F;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChNine       = 8'h39;
  localparam logic [7:0] ChLt         = 8'h3C;
  localparam logic [7:0] ChQuestion   = 8'h3F;
  localparam logic [7:0] ChUpperA     = 8'h41;
  localparam logic [7:0] ChUpperZ     = 8'h5A;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChLowerA     = 8'h61;
  localparam logic [7:0] ChLowerZ     = 8'h7A;

  typedef enum logic [2:0] {
    KIND_END      = 3'd0,
    KIND_IDENT    = 3'd1,
    KIND_VARIABLE = 3'd2,
    KIND_INTEGER  = 3'd3,
    KIND_ENTITY   = 3'd4,
    KIND_IMPLIED  = 3'd5,
    KIND_CHAR     = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          char_code;
    logic signed [31:0]  value;
    logic [31:0]         line;
    logic [31:0]         start_index;
    logic [LenOutW-1:0]  length;
    logic                truncated;
    logic                last;
  } out_item_t;

  // Results caused by one input item; res0 is always used.
  typedef struct packed {
    out_item_t res0;
    out_item_t res1;
    logic      two;
  } tok_pair_t;

endpackage

### sv/llt_lexer.sv
// Front part: accepts text bytes, tracks lexing mode, counters and accumulator.
// Produces up to two finished tokens per byte as one queue entry. Uses llt_pkg.
module llt_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  llt_pkg::in_item_t in_data_i,
  output logic              entry_valid_o,
  output llt_pkg::tok_pair_t entry_o
);
  import llt_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_IDENT   = 4'd1,
    M_VAR     = 4'd2,
    M_INT     = 4'd3,
    M_ENTITY  = 4'd4,
    M_LT      = 4'd5,
    M_SLASH   = 4'd6,
    M_COMMENT = 4'd7
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [31:0]      acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [31:0]      start_q, start_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [31:0]      line_q, line_d;
  logic [31:0]      idx_q, idx_d;

  logic [7:0]       c;
  logic             is_end, is_alpha, is_digit, is_ident, is_space;
  logic [3:0]       dig;
  logic [LenW-1:0]  len_inc;
  logic             trunc_hit;
  logic [31:0]      acc_upd;
  logic             used;
  logic             e1v, e2v;
  out_item_t        e1, e2, r0;

  function automatic out_item_t make_rec(kind_e kind, logic [7:0] code, logic [31:0] value,
                                         logic [31:0] start, logic [LenOutW-1:0] len,
                                         logic trunc, logic [31:0] line);
    out_item_t r;
    r.kind        = kind;
    r.char_code   = code;
    r.value       = $signed(value);
    r.line        = line;
    r.start_index = start;
    r.length      = len;
    r.truncated   = trunc;
    r.last        = 1'b0;
    return r;
  endfunction

  // Build the record of the token pending in the given mode.
  function automatic out_item_t pend_rec(mode_e mode, logic [31:0] start, logic [LenW-1:0] len,
                                         logic [31:0] acc, logic trunc, logic [31:0] line);
    out_item_t r;
    case (mode)
      M_IDENT:  r = make_rec(KIND_IDENT, 8'd0, 32'd0, start, LenOutW'(len), trunc, line);
      M_VAR:    r = make_rec(KIND_VARIABLE, 8'd0, 32'd0, start, LenOutW'(len), trunc, line);
      M_INT:    r = make_rec(KIND_INTEGER, 8'd0, acc, start, LenOutW'(len), trunc, line);
      M_ENTITY: r = make_rec(KIND_ENTITY, 8'd0, acc, start, LenOutW'(len), trunc, line);
      M_LT:     r = make_rec(KIND_CHAR, ChLt, 32'd0, start, LenOutW'(1), 1'b0, line);
      M_SLASH:  r = make_rec(KIND_CHAR, ChSlash, 32'd0, start, LenOutW'(1), 1'b0, line);
      default:  r = '0;
    endcase
    return r;
  endfunction

  // Classify the byte
  assign c         = in_data_i.ch;
  assign is_end    = in_data_i.is_end | (c == ChNul);
  assign is_alpha  = ((c >= ChUpperA) && (c <= ChUpperZ)) || ((c >= ChLowerA) && (c <= ChLowerZ));
  assign is_digit  = (c >= ChZero) && (c <= ChNine);
  assign is_ident  = is_alpha | is_digit | (c == ChUnderscore);
  assign is_space  = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  assign dig       = 4'(c - ChZero);
  assign len_inc   = len_q + 1'b1;
  assign trunc_hit = (len_inc >= LenW'(TokenLimit - 1));
  // Signed accumulate: value * 10 plus or minus the digit
  assign acc_upd   = (acc_q << 3) + (acc_q << 1) + (neg_q ? (32'd0 - {28'd0, dig}) : {28'd0, dig});

  // Next state and emitted tokens
  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    start_d = start_q;
    len_d   = len_q;
    line_d  = line_q;
    idx_d   = idx_q;
    used    = 1'b0;
    e1v     = 1'b0;
    e1      = '0;
    e2v     = 1'b0;
    e2      = '0;

    if (is_end) begin
      // Flush pending token, drop a pending comment, then restart
      if (mode_q != M_COMMENT && mode_q != M_IDLE) begin
        e1v = 1'b1;
        e1  = pend_rec(mode_q, start_q, len_q, acc_q, 1'b0, line_q);
      end
      e2v     = 1'b1;
      e2      = make_rec(KIND_END, 8'd0, 32'd0, idx_q, LenOutW'(1), 1'b0, line_q);
      mode_d  = M_IDLE;
      acc_d   = '0;
      neg_d   = 1'b0;
      start_d = '0;
      len_d   = '0;
      line_d  = 32'd1;
      idx_d   = 32'd1;
    end else begin
      case (mode_q)
        M_IDENT, M_VAR: begin
          if (is_ident) begin
            used  = 1'b1;
            len_d = len_inc;
            if (trunc_hit) begin
              e1v    = 1'b1;
              e1     = pend_rec(mode_q, start_q, len_inc, acc_q, 1'b1, line_q);
              mode_d = M_IDLE;
            end
          end else begin
            e1v    = 1'b1;
            e1     = pend_rec(mode_q, start_q, len_q, acc_q, 1'b0, line_q);
            mode_d = M_IDLE;
          end
        end
        M_INT, M_ENTITY: begin
          if (is_digit) begin
            used  = 1'b1;
            len_d = len_inc;
            acc_d = acc_upd;
            if (trunc_hit) begin
              e1v    = 1'b1;
              e1     = pend_rec(mode_q, start_q, len_inc, acc_upd, 1'b1, line_q);
              mode_d = M_IDLE;
            end
          end else begin
            e1v    = 1'b1;
            e1     = pend_rec(mode_q, start_q, len_q, acc_q, 1'b0, line_q);
            mode_d = M_IDLE;
          end
        end
        M_LT: begin
          e1v    = 1'b1;
          mode_d = M_IDLE;
          if (c == ChMinus) begin
            used = 1'b1;
            e1   = make_rec(KIND_IMPLIED, 8'd0, 32'd0, start_q, LenOutW'(2), 1'b0, line_q);
          end else begin
            e1 = pend_rec(mode_q, start_q, len_q, acc_q, 1'b0, line_q);
          end
        end
        M_SLASH: begin
          if (c == ChSlash) begin
            used   = 1'b1;
            mode_d = M_COMMENT;
          end else begin
            e1v    = 1'b1;
            e1     = pend_rec(mode_q, start_q, len_q, acc_q, 1'b0, line_q);
            mode_d = M_IDLE;
          end
        end
        M_COMMENT: begin
          if (c != ChLf) begin
            used = 1'b1;
          end else begin
            mode_d = M_IDLE;
          end
        end
        default: begin
          mode_d = M_IDLE;
        end
      endcase

      // Start a new token from a byte not consumed above
      if (!used && !is_space) begin
        if (is_alpha || c == ChUnderscore) begin
          mode_d  = M_IDENT;
          start_d = idx_q;
          len_d   = LenW'(1);
        end else if (is_digit || c == ChMinus) begin
          mode_d  = M_INT;
          start_d = idx_q;
          len_d   = LenW'(1);
          neg_d   = (c == ChMinus);
          acc_d   = is_digit ? {28'd0, dig} : 32'd0;
        end else if (c == ChLt) begin
          mode_d  = M_LT;
          start_d = idx_q;
        end else if (c == ChSlash) begin
          mode_d  = M_SLASH;
          start_d = idx_q;
        end else if (c == ChQuestion) begin
          mode_d  = M_VAR;
          start_d = idx_q + 32'd1;
          len_d   = '0;
        end else if (c == ChHash) begin
          mode_d  = M_ENTITY;
          start_d = idx_q + 32'd1;
          len_d   = '0;
          acc_d   = '0;
          neg_d   = 1'b0;
        end else begin
          e2v = 1'b1;
          e2  = make_rec(KIND_CHAR, c, 32'd0, idx_q, LenOutW'(1), 1'b0, line_q);
        end
      end

      idx_d  = idx_q + 32'd1;
      line_d = line_q + {31'd0, (c == ChLf)};
    end
  end

  // Pack emitted tokens into one entry, first token in slot zero
  always_comb begin
    r0            = e1v ? e1 : e2;
    r0.last       = ~(e1v & e2v);
    entry_o.res0  = r0;
    entry_o.res1  = e2;
    entry_o.res1.last = 1'b1;
    entry_o.two   = e1v & e2v;
    entry_valid_o = accept_i & (e1v | e2v);
  end

  // Hold lexer state; advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      line_q  <= 32'd1;
      idx_q   <= 32'd1;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      start_q <= start_d;
      len_q   <= len_d;
      line_q  <= line_d;
      idx_q   <= idx_d;
    end
  end

endmodule

### sv/llt_fifo.sv
// Short queue of token entries between the lexer and the serializer.
// Entry type comes from llt_pkg.
module llt_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  llt_pkg::tok_pair_t wr_data_i,
  output logic               full_o,
  input  logic               rd_i,
  output llt_pkg::tok_pair_t rd_data_o,
  output logic               empty_o
);
  import llt_pkg::*;

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);

  tok_pair_t       slots_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(FifoDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & ~empty_o;
  assign rd_data_o = slots_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### sv/llt_serializer.sv
// Back part: takes token entries from the queue and presents their results one at
// a time in an output register. Uses llt_pkg.
module llt_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fifo_empty_i,
  input  llt_pkg::tok_pair_t fifo_data_i,
  output logic               fifo_rd_o,
  output logic               empty_o,
  input  logic               pop_i,
  output llt_pkg::out_item_t out_data_o
);
  import llt_pkg::*;

  tok_pair_t cur_q;
  logic      valid_q;
  logic      slot_q;
  logic      take, done, load;

  assign take       = pop_i & valid_q;
  assign done       = take & (slot_q | ~cur_q.two);
  assign load       = ~valid_q | done;
  assign fifo_rd_o  = load & ~fifo_empty_i;
  assign empty_o    = ~valid_q;
  assign out_data_o = slot_q ? cur_q.res1 : cur_q.res0;

  // Hold current entry payload
  always_ff @(posedge clk_i) begin
    if (fifo_rd_o) begin
      cur_q <= fifo_data_i;
    end
  end

  // Advance through the entry's results; refill from the queue when done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= 1'b0;
    end else if (load) begin
      valid_q <= ~fifo_empty_i;
      slot_q  <= 1'b0;
    end else if (take) begin
      slot_q  <= 1'b1;
    end
  end

endmodule

### sv/logic_language_tokenizer.sv
// Logic language tokenizer: text bytes in, tokens out.
// Top level; instantiates llt_lexer, llt_fifo and llt_serializer from llt_pkg types.
//
// Usage:
//   Input queue: drive in_data_i (ch, is_end) with push_i; a request is taken
//   at a clock edge where push_i is high and full_o is low. A zero byte acts
//   like is_end. One byte is taken per cycle while full_o stays low.
//   Output queue: while empty_o is low, out_data_o shows the oldest token;
//   pop_i at such an edge takes it. Up to one token leaves per cycle.
//   A token appears when the byte that ends it is taken; one byte may release
//   two tokens (the pending one and a one-character or end token), the second
//   marked by last. Tokens pass via the token queue to the output register.
//   The lexer handles each taken byte at once; a 4-entry token queue and the
//   output register decouple it from the receiver. When the receiver stalls,
//   the queue fills and full_o rises; no byte or token is lost.
//   Reset clears lexing mode to idle, line and index to 1 and empties both
//   queues. After an end token the same restart happens on its own.
module logic_language_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  llt_pkg::in_item_t   in_data_i,
  output logic                empty_o,
  input  logic                pop_i,
  output llt_pkg::out_item_t  out_data_o
);
  import llt_pkg::*;

  logic      accept;
  logic      entry_valid;
  tok_pair_t entry;
  logic      fifo_full, fifo_empty, fifo_rd;
  tok_pair_t fifo_data;

  assign full_o = fifo_full;
  assign accept = push_i & ~fifo_full;

  llt_lexer u_lexer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_data_i     (in_data_i),
    .entry_valid_o (entry_valid),
    .entry_o       (entry)
  );

  llt_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (entry_valid),
    .wr_data_i (entry),
    .full_o    (fifo_full),
    .rd_i      (fifo_rd),
    .rd_data_o (fifo_data),
    .empty_o   (fifo_empty)
  );

  llt_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_data_i  (fifo_data),
    .fifo_rd_o    (fifo_rd),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_data_o   (out_data_o)
  );

  // An accepted end request always leaves an entry in the queue
  a_end_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.is_end || in_data_i.ch == ChNul)) |=> !fifo_empty)
    else $error("end request produced no queue entry");

  // The end token is always the final token of its request
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_data_o.kind == KIND_END) |-> out_data_o.last)
    else $error("end token not marked last");

  // A token that is not last is followed by its partner without a gap
  a_pair_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !out_data_o.last) |=> !empty_o)
    else $error("second token of a pair went missing");

endmodule

### sim/logic_language_tokenizer_tb.sv
// Self-checking testbench for logic_language_tokenizer: text bytes in, tokens out.
// Holds its own token predictor and a queue of expected tokens; needs llt_pkg and the RTL.
`timescale 1ns / 1ps

module logic_language_tokenizer_tb;
  import llt_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 400;

  typedef enum int {
    LX_IDLE, LX_IDENT, LX_VAR, LX_INT, LX_ENTITY, LX_LT, LX_SLASH, LX_COMMENT
  } lex_mode_e;

  // One directed request, with a hand-typed token where it is obvious.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t tok;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push_i;
  logic      full_o;
  in_item_t  in_data_i;
  logic      empty_o;
  logic      pop_i;
  out_item_t out_data_o;

  // Token predictor state.
  lex_mode_e   p_mode;
  logic [31:0] p_accum;
  bit          p_neg;
  logic [31:0] p_start;
  int          p_len;
  logic [31:0] p_line;
  logic [31:0] p_index;
  out_item_t   step_toks[$];

  out_item_t   tok_exp_q[$];
  dir_row_t    dir_q[$];
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          cycle_cnt = 0;
  int          rx_hold_left = 0;
  bit          rx_hold_req = 1'b0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  logic_language_tokenizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_data_i  (in_data_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Character classes.
  function automatic bit is_letter(logic [7:0] c);
    return (c >= ChUpperA && c <= ChUpperZ) || (c >= ChLowerA && c <= ChLowerZ);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic bit is_word_ch(logic [7:0] c);
    return is_letter(c) || is_num(c) || c == ChUnderscore;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic void lex_clear();
    p_mode  = LX_IDLE;
    p_accum = '0;
    p_neg   = 1'b0;
    p_start = '0;
    p_len   = 0;
    p_line  = 32'd1;
    p_index = 32'd1;
  endfunction

  // Append a token for this request; at most two per request.
  function automatic void emit_tok(kind_e k, logic [7:0] code, logic [31:0] val,
                                   logic [31:0] start, int len, bit trunc);
    out_item_t t;
    if (step_toks.size() >= 2) return;
    t.kind        = k;
    t.char_code   = code;
    t.value       = val;
    t.line        = p_line;
    t.start_index = start;
    t.length      = len[LenOutW-1:0];
    t.truncated   = trunc;
    t.last        = 1'b0;
    step_toks.push_back(t);
  endfunction

  // Release whatever token is pending and drop back to idle.
  function automatic void flush_pending(bit trunc);
    case (p_mode)
      LX_IDENT:  emit_tok(KIND_IDENT, '0, '0, p_start, p_len, trunc);
      LX_VAR:    emit_tok(KIND_VARIABLE, '0, '0, p_start, p_len, trunc);
      LX_INT:    emit_tok(KIND_INTEGER, '0, p_neg ? -p_accum : p_accum, p_start, p_len, trunc);
      LX_ENTITY: emit_tok(KIND_ENTITY, '0, p_accum, p_start, p_len, trunc);
      LX_LT:     emit_tok(KIND_CHAR, ChLt, '0, p_start, 1, 1'b0);
      LX_SLASH:  emit_tok(KIND_CHAR, ChSlash, '0, p_start, 1, 1'b0);
      default: ;
    endcase
    p_mode = LX_IDLE;
  endfunction

  // Extend the token; cut it once it reaches the limit.
  function automatic void grow();
    p_len++;
    if (p_len >= TokenLimit - 1) flush_pending(1'b1);
  endfunction

  // Advance the predictor by one request; tokens land in step_toks.
  function automatic void lex_step(in_item_t it);
    logic [7:0]  c;
    logic [31:0] idx;
    bit          stop;
    bit          taken;
    c     = it.ch;
    idx   = p_index;
    stop  = it.is_end || c == ChNul;
    taken = 1'b0;
    step_toks.delete();
    if (stop) begin
      if (p_mode == LX_COMMENT) p_mode = LX_IDLE;
      else flush_pending(1'b0);
      emit_tok(KIND_END, '0, '0, p_index, 1, 1'b0);
      lex_clear();
    end else begin
      case (p_mode)
        LX_IDENT, LX_VAR: begin
          if (is_word_ch(c)) begin
            taken = 1'b1;
            grow();
          end else flush_pending(1'b0);
        end
        LX_INT, LX_ENTITY: begin
          if (is_num(c)) begin
            taken = 1'b1;
            p_accum = p_accum * 32'd10 + 32'(c - ChZero);
            grow();
          end else flush_pending(1'b0);
        end
        LX_LT: begin
          if (c == ChMinus) begin
            taken = 1'b1;
            emit_tok(KIND_IMPLIED, '0, '0, p_start, 2, 1'b0);
            p_mode = LX_IDLE;
          end else flush_pending(1'b0);
        end
        LX_SLASH: begin
          if (c == ChSlash) begin
            taken = 1'b1;
            p_mode = LX_COMMENT;
          end else flush_pending(1'b0);
        end
        LX_COMMENT: begin
          if (c != ChLf) taken = 1'b1;
          else p_mode = LX_IDLE;
        end
        default: p_mode = LX_IDLE;
      endcase
      // Start a fresh token from a byte nobody consumed.
      if (!taken && !is_blank(c)) begin
        if (is_letter(c) || c == ChUnderscore) begin
          p_mode  = LX_IDENT;
          p_start = idx;
          p_len   = 0;
          grow();
        end else if (is_num(c) || c == ChMinus) begin
          p_mode  = LX_INT;
          p_start = idx;
          p_len   = 0;
          p_neg   = (c == ChMinus);
          p_accum = is_num(c) ? 32'(c - ChZero) : 32'd0;
          grow();
        end else if (c == ChLt) begin
          p_mode  = LX_LT;
          p_start = idx;
        end else if (c == ChSlash) begin
          p_mode  = LX_SLASH;
          p_start = idx;
        end else if (c == ChQuestion) begin
          p_mode  = LX_VAR;
          p_start = idx + 32'd1;
          p_len   = 0;
        end else if (c == ChHash) begin
          p_mode  = LX_ENTITY;
          p_start = idx + 32'd1;
          p_len   = 0;
          p_accum = '0;
          p_neg   = 1'b0;
        end else begin
          emit_tok(KIND_CHAR, c, '0, idx, 1, 1'b0);
        end
      end
      p_index++;
      if (c == ChLf) p_line++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
  endfunction

  function automatic in_item_t mk_in(logic [7:0] c, logic e);
    in_item_t it;
    it.ch     = c;
    it.is_end = e;
    return it;
  endfunction

  // Single-width token on line 1, typed in by hand.
  function automatic out_item_t one_tok(kind_e k, logic [7:0] code, logic [31:0] start);
    out_item_t t;
    t             = '0;
    t.kind        = k;
    t.char_code   = code;
    t.line        = 32'd1;
    t.start_index = start;
    t.length      = 5'd1;
    t.last        = 1'b1;
    return t;
  endfunction

  // Offer one request, hold it until accepted, then record the tokens it causes.
  task automatic offer_byte(input in_item_t it, input bit typed, input out_item_t want);
    while (tx_idle_en && $urandom_range(99) < 20) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    lex_step(it);
    if (typed && step_toks.size() > 0) step_toks[0] = want;
    foreach (step_toks[i]) tok_exp_q.push_back(step_toks[i]);
    sent_cnt++;
  endtask

  task automatic put_ch(input logic [7:0] c);
    offer_byte(mk_in(c, 1'b0), 1'b0, '0);
  endtask

  function automatic int rnd_len(int short_max);
    if ($urandom_range(99) < 10) return $urandom_range(35, 25);
    return $urandom_range(short_max, 1);
  endfunction

  function automatic logic [7:0] rnd_word_ch();
    int r;
    r = $urandom_range(62);
    if (r < 26) return ChLowerA + 8'(r);
    if (r < 52) return ChUpperA + 8'(r - 26);
    if (r < 62) return ChZero + 8'(r - 52);
    return ChUnderscore;
  endfunction

  function automatic logic [7:0] rnd_digit();
    return ChZero + 8'($urandom_range(9));
  endfunction

  // Emit one random phrase: mostly well-formed tokens, some noise and ends.
  task automatic gen_phrase();
    string      punct;
    int         r;
    int         n;
    logic [7:0] c;
    punct = "(),.;:!=+*&|[]{}~@$%^>";
    r = $urandom_range(99);
    if (r < 25) begin
      c = ($urandom_range(9) == 0) ? ChUnderscore :
          ($urandom_range(1) ? ChLowerA : ChUpperA) + 8'($urandom_range(25));
      put_ch(c);
      n = rnd_len(8);
      repeat (n - 1) put_ch(rnd_word_ch());
    end else if (r < 35) begin
      put_ch(ChQuestion);
      n = rnd_len(8) - $urandom_range(1);
      repeat (n) put_ch(rnd_word_ch());
    end else if (r < 50) begin
      if ($urandom_range(99) < 30) begin
        put_ch(ChMinus);
        n = rnd_len(6) - $urandom_range(1);
      end else begin
        n = rnd_len(6);
      end
      repeat (n) put_ch(rnd_digit());
    end else if (r < 58) begin
      put_ch(ChHash);
      n = rnd_len(6) - $urandom_range(1);
      repeat (n) put_ch(rnd_digit());
    end else if (r < 64) begin
      put_ch(ChLt);
      put_ch(ChMinus);
    end else if (r < 68) begin
      put_ch($urandom_range(1) ? ChLt : ChSlash);
    end else if (r < 73) begin
      put_ch(ChSlash);
      put_ch(ChSlash);
      repeat ($urandom_range(10)) begin
        c = 8'($urandom_range(255, 1));
        put_ch(c == ChLf ? ChSpace : c);
      end
      put_ch(ChLf);
    end else if (r < 83) begin
      put_ch(punct[$urandom_range(punct.len() - 1)]);
    end else if (r < 95) begin
      put_ch(8'($urandom_range(255, 1)));
    end else if (r < 98) begin
      offer_byte(mk_in(8'($urandom_range(255)), 1'b1), 1'b0, '0);
    end else begin
      put_ch(ChNul);
    end
    // Separate with blanks now and then, or let tokens touch.
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(5))
        0: put_ch(ChSpace);
        1: put_ch(ChTab);
        2: put_ch(ChLf);
        3: put_ch(8'h0B);
        4: put_ch(8'h0C);
        default: put_ch(ChCr);
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      err_cnt++;
    end
  endtask

  // Compare each popped token with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && pop_i && !empty_o) begin
      if (tok_exp_q.size() == 0) begin
        $error("token with no expectation waiting: kind %0d", out_data_o.kind);
        err_cnt++;
      end else begin
        e = tok_exp_q.pop_front();
        check_field("kind", 32'(e.kind), 32'(out_data_o.kind));
        check_field("char_code", 32'(e.char_code), 32'(out_data_o.char_code));
        check_field("value", e.value, out_data_o.value);
        check_field("line", e.line, out_data_o.line);
        check_field("start_index", e.start_index, out_data_o.start_index);
        check_field("length", 32'(e.length), 32'(out_data_o.length));
        check_field("truncated", 32'(e.truncated), 32'(out_data_o.truncated));
        check_field("last", 32'(e.last), 32'(out_data_o.last));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    pop_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_hold_left = HoldCycles;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= !rx_idle_en || ($urandom_range(99) >= 20);
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    push_i    = 1'b0;
    in_data_i = '0;
    rst_ni    = 1'b0;
    lex_clear();

    // Directed: extremes, every token kind, lone prefixes, comments, ends.
    dir_q.push_back('{mk_in("+", 1'b0), 1'b1, one_tok(KIND_CHAR, "+", 32'd1)});
    dir_q.push_back('{mk_in(8'hFF, 1'b1), 1'b1, one_tok(KIND_END, '0, 32'd2)});
    dir_q.push_back('{mk_in(ChNul, 1'b0), 1'b1, one_tok(KIND_END, '0, 32'd1)});
    dir_q.push_back('{mk_in("x", 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChLt, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChMinus, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChQuestion, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChHash, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in("7", 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChSlash, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in("q", 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChLt, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in("A", 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChMinus, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChSpace, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChSlash, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChSlash, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in("Z", 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChLf, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in("9", 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChNul, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChSlash, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(ChSlash, 1'b0), 1'b0, '0});
    dir_q.push_back('{mk_in(8'h00, 1'b1), 1'b1, one_tok(KIND_END, '0, 32'd3)});
    dir_q.push_back('{mk_in(8'hFF, 1'b0), 1'b1, one_tok(KIND_CHAR, 8'hFF, 32'd1)});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) offer_byte(dir_q[i].item, dir_q[i].typed, dir_q[i].tok);

    // Random text with idling on both sides.
    while (sent_cnt < 400) gen_phrase();

    // Long stretch with no idling at all.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (sent_cnt < 650) gen_phrase();
    rx_idle_en = 1'b1;

    // Hold the receiver off and keep offering one-character requests.
    rx_hold_req = 1'b1;
    repeat (60) put_ch("+");
    tx_idle_en = 1'b1;

    // Pause the sender until every expected token has come.
    push_i <= 1'b0;
    do @(posedge clk_i); while (tok_exp_q.size() != 0);

    while (sent_cnt < 1260) gen_phrase();
    offer_byte(mk_in(ChNul, 1'b1), 1'b0, '0);

    // Drain and let the pipeline settle.
    push_i <= 1'b0;
    do @(posedge clk_i); while (tok_exp_q.size() != 0);
    repeat (30) @(posedge clk_i);

    if (tok_exp_q.size() != 0) begin
      $error("%0d expected tokens never arrived", tok_exp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
